@@ rtl/spq_pkg.sv @@
// Shared types and codes for the stable priority queue.
package spq_pkg;

	localparam int unsigned DataW    = 32;
	localparam int unsigned CountOutW = 5;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one stored entry
	typedef struct packed {
		logic [DataW-1:0] value;
		logic [DataW-1:0] prio;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             push_en;
		logic             pop_en;
		logic [DataW-1:0] value;
		logic [DataW-1:0] prio;
	} cell_ctrl_t;

endpackage

@@ rtl/spq_cell.sv @@
// One slot of the sorted queue: compare against the pushed priority and shift.
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occupied,
	input  logic       left_ge,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	output logic       ge,
	output entry_t     entry,
	output entry_t     entry_d
);

	entry_t entry_q;

	// stored entry ranks ahead of (or ties with) the new one
	assign ge = occupied && ($signed(entry_q.prio) >= $signed(ctrl.prio));

	always_comb begin
		entry_d = entry_q;
		if (ctrl.push_en) begin
			if (!ge) begin
				if (left_ge) begin
					entry_d.value = ctrl.value;
					entry_d.prio  = ctrl.prio;
				end else begin
					entry_d = left_entry;
				end
			end
		end else if (ctrl.pop_en) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

@@ rtl/stable_priority_queue_core.sv @@
// Top level of the stable priority queue: cell chain, count and result register.
// The result word for a command is presented in the cycle after it is accepted.
// Throughput: one command word per cycle unless the output stalls; every slot compares and
//   shifts in parallel, so its 32-bit priority compare plus shift select sets the clock.
// Reset (arst_n low) clears the entry count and the output valid; slot contents stay
//   undefined and are never observed, since only slots below the count are read.
module stable_priority_queue_core
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] value, [63:32] priority_req
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] head_value, [32] head_valid,
	                               // [37:33] entry_count, [39:38] status
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned WW = (CW > CountOutW) ? CW : CountOutW;

	// ---------------------------------------------------------------
	// Input decode
	// ---------------------------------------------------------------
	logic          accept;
	cmd_t          cmd;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          full;
	logic          empty;
	status_t       status_d;
	cell_ctrl_t    ctrl;

	assign accept = s_tvalid && s_tready;
	assign cmd    = cmd_t'(s_tuser);
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		ctrl.push_en = 1'b0;
		ctrl.pop_en  = 1'b0;
		ctrl.value   = s_tdata[31:0];
		ctrl.prio    = s_tdata[63:32];
		count_d      = count_q;
		status_d     = ST_OK;
		if (accept) begin
			unique case (cmd)
				CMD_PUSH: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ctrl.push_en = 1'b1;
						count_d      = count_q + CW'(1);
					end
				end
				CMD_POP: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						ctrl.pop_en = 1'b1;
						count_d     = count_q - CW'(1);
					end
				end
				CMD_CLEAR: count_d = '0;
				default:   count_d = count_q; // unused code leaves the queue alone
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// ---------------------------------------------------------------
	// Cell chain: slot 0 is the head. On push, the first cell that does not
	// rank ahead of the new word takes it and everything behind shifts back.
	// On pop, every cell but the tail takes its right neighbor; the tail keeps its own.
	// ---------------------------------------------------------------
	logic   [DEPTH-1:0] ge;
	entry_t             entry   [DEPTH];
	entry_t             entry_d [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occupied;
		logic   left_ge;
		entry_t left_entry;
		entry_t right_entry;

		assign occupied = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_ge    = 1'b1;
			assign left_entry = entry[0];
		end else begin : g_body
			assign left_ge    = ge[i-1];
			assign left_entry = entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_entry = entry[i];
		end else begin : g_mid
			assign right_entry = entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occupied),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.ge          (ge[i]),
			.entry       (entry[i]),
			.entry_d     (entry_d[i])
		);
	end

	// ---------------------------------------------------------------
	// Result word register; a new command is taken while the held word drains
	// ---------------------------------------------------------------
	logic          m_valid_q;
	logic [39:0]   m_data_q;
	logic          head_valid_d;
	logic [WW-1:0] count_wide;

	assign head_valid_d = (count_d != '0);
	assign count_wide   = WW'(count_d);
	assign s_tready     = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q[31:0]  <= head_valid_d ? entry_d[0].value : '0;
			m_data_q[32]    <= head_valid_d;
			m_data_q[37:33] <= count_wide[CountOutW-1:0];
			m_data_q[39:38] <= status_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_PUSH && full |=> count_q == CW'(DEPTH) && m_data_q[39:38] == ST_FULL)
		else $error("push on full not dropped");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_data_q[32] |-> m_data_q[31:0] == '0)
		else $error("head value nonzero while empty");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_valid_q)
		else $error("accepted command produced no result");

endmodule

@@ verif/stable_priority_queue_core_tb.sv @@
// Self-checking testbench for the stable priority queue core.
`timescale 1ns / 1ps

module stable_priority_queue_core_tb;
	import spq_pkg::*;

	localparam int QDEPTH    = 16;
	localparam int CYCLE_CAP = 400000;

	// one result word, fields in packing order from the top down
	typedef struct packed {
		status_t     status;
		logic [4:0]  entry_count;
		logic        head_valid;
		logic [31:0] head_value;
	} head_report_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [63:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [39:0] m_tdata;

	// shadow copy of the sorted queue
	logic signed [31:0] shadow_value [QDEPTH];
	logic signed [31:0] shadow_prio  [QDEPTH];
	int                 shadow_count = 0;

	head_report_t pending_reports [$];

	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_odds = 30;
	int hold_len = 0;
	int rx_phase = 0;
	int stall_pct = 0;
	int n_push = 0, n_dropped = 0, n_pop = 0, n_pop_empty = 0;
	int n_clear = 0, n_unused = 0, n_checked = 0;

	stable_priority_queue_core #(.DEPTH(QDEPTH)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Applies one command to the shadow queue and returns the word it should produce.
	function automatic head_report_t apply_command(cmd_t op, logic signed [31:0] val,
	                                               logic signed [31:0] pri);
		head_report_t r;
		int pos;
		int i;
		r.status = ST_OK;
		case (op)
			CMD_PUSH: begin
				if (shadow_count >= QDEPTH) begin
					r.status = ST_FULL;
				end else begin
					// new entry lands behind every entry of equal or higher priority
					pos = 0;
					while (pos < shadow_count && shadow_prio[pos] >= pri) pos++;
					for (i = shadow_count; i > pos; i--) begin
						shadow_value[i] = shadow_value[i-1];
						shadow_prio[i]  = shadow_prio[i-1];
					end
					shadow_value[pos] = val;
					shadow_prio[pos]  = pri;
					shadow_count++;
				end
			end
			CMD_POP: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (i = 0; i + 1 < shadow_count; i++) begin
						shadow_value[i] = shadow_value[i+1];
						shadow_prio[i]  = shadow_prio[i+1];
					end
					shadow_count--;
				end
			end
			CMD_CLEAR: shadow_count = 0;
			default: ;
		endcase
		r.head_valid  = (shadow_count > 0);
		r.head_value  = (shadow_count > 0) ? shadow_value[0] : 32'd0;
		r.entry_count = 5'(shadow_count);
		return r;
	endfunction

	// Offers one command word; bursts and gaps are decided here.
	task automatic send_word(cmd_t op, logic [31:0] val, logic [31:0] pri);
		head_report_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 99) < gap_odds) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pri, val};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		r = apply_command(op, val, pri);
		pending_reports.push_back(r);
		case (op)
			CMD_PUSH:  begin n_push++; if (r.status == ST_FULL) n_dropped++; end
			CMD_POP:   begin n_pop++; if (r.status == ST_EMPTY) n_pop_empty++; end
			CMD_CLEAR: n_clear++;
			default:   n_unused++;
		endcase
		burst_left--;
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic send_random(int push_pct);
		int roll;
		logic [31:0] pri;
		roll = $urandom_range(0, 99);
		// narrow priorities give plenty of ties, wide ones cover every bit
		if ($urandom_range(0, 9) < 6) pri = 32'($urandom_range(0, 7)) - 32'd4;
		else pri = $urandom;
		if (roll < 2) send_word(CMD_CLEAR, $urandom, pri);
		else if (roll < 4) send_word(CMD_NONE, $urandom, pri);
		else if (roll < 4 + push_pct) send_word(CMD_PUSH, $urandom, pri);
		else send_word(CMD_POP, $urandom, pri);
	endtask

	task automatic test_empty_cases();
		send_word(CMD_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(CMD_CLEAR, $urandom, $urandom);
		send_word(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_tie_order();
		send_word(CMD_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(CMD_PUSH, 32'h8000_0000, 32'h8000_0000);
		send_word(CMD_PUSH, 32'd1, 32'd0);
		send_word(CMD_PUSH, 32'd2, 32'd0);
		send_word(CMD_PUSH, 32'd3, 32'hFFFF_FFFF);
		send_word(CMD_PUSH, 32'd4, 32'h7FFF_FFFF);
		send_word(CMD_PUSH, 32'd5, 32'h8000_0000);
		send_word(CMD_POP, $urandom, $urandom);
	endtask

	task automatic test_full();
		while (shadow_count < QDEPTH) send_word(CMD_PUSH, $urandom, 32'($urandom_range(0, 3)));
		send_word(CMD_PUSH, $urandom, 32'h7FFF_FFFF);
		send_word(CMD_NONE, $urandom, $urandom);
		send_word(CMD_CLEAR, $urandom, $urandom);
	endtask

	task automatic test_random(int n_items);
		int left;
		int push_pct;
		int k;
		left = n_items;
		while (left > 0) begin
			// each phase leans toward filling, draining or churning
			case ($urandom_range(0, 2))
				0:       push_pct = 20;
				1:       push_pct = 48;
				default: push_pct = 80;
			endcase
			case ($urandom_range(0, 2))
				0:       gap_odds = 0;
				1:       gap_odds = 30;
				default: gap_odds = 70;
			endcase
			k = $urandom_range(40, 120);
			if (k > left) k = left;
			repeat (k) send_random(push_pct);
			left -= k;
		end
	endtask

	task automatic test_backpressure();
		gap_odds = 0;
		hold_len = 120;
		repeat (50) send_random(60);
	endtask

	task automatic test_pause();
		wait_all_results();
		gap_odds = 30;
		repeat (40) send_random(50);
	endtask

	// receiver: stall rate changes per stretch, long hold-offs on request
	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_len--;
			m_tready <= 1'b0;
		end else begin
			if (rx_phase == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 20;
					2:       stall_pct = 50;
					default: stall_pct = 85;
				endcase
				rx_phase = $urandom_range(50, 200);
			end
			rx_phase--;
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		head_report_t want;
		head_report_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			n_checked++;
			if (pending_reports.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (got.head_value !== want.head_value) begin
					$error("head_value: expected %h, actual %h", want.head_value, got.head_value);
					errors++;
				end
				if (got.head_valid !== want.head_valid) begin
					$error("head_valid: expected %b, actual %b", want.head_valid, got.head_valid);
					errors++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
					       want.entry_count, got.entry_count);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_cases();
		test_tie_order();
		test_full();
		test_random(1400);
		test_backpressure();
		test_pause();
		wait_all_results();
		repeat (4) @(posedge clk);
		$display("Run covered %0d pushes (%0d dropped on full), %0d pops (%0d on empty),",
		         n_push, n_dropped, n_pop, n_pop_empty);
		$display("  %0d clears, %0d unused codes; %0d result words checked",
		         n_clear, n_unused, n_checked);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_core.sv
verif/stable_priority_queue_core_tb.sv
